@@ rtl/core/imuhid_pkg.sv @@
// ----------------------------------------------------------------------------
// imuhid_pkg
// Shared types and constants for the motion packet to HID report unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imuhid_pkg;

    // number of sensor axes for accel and gyro
    localparam int AXES = 3;

    // default log2 of the accel averaging window
    localparam int AVG_LOG2_DEF = 2;

    // mouse deltas are counted in units of 2^MOUSE_SHIFT
    localparam int MOUSE_SHIFT = 8;

    // input and output beat widths
    localparam int S_DATA_W = 224;
    localparam int M_DATA_W = 240;

    typedef logic signed [7:0]  s8_t;
    typedef logic signed [15:0] s16_t;
    typedef logic signed [31:0] s32_t;

    // per-beat control from the top level to the state blocks
    typedef struct packed {
        logic advance;   // input register beat is consumed this cycle
        logic last;      // consumed beat closes a batch
    } ctl_t;

    // gyro derived report fields
    typedef struct packed {
        s8_t  mouse_dx;
        s8_t  mouse_dy;
        s16_t joy_rx;
        s16_t joy_ry;
        s16_t joy_rz;
    } gyro_rpt_t;

endpackage

`default_nettype wire

@@ rtl/core/imu_packet_to_hid_report_unit.sv @@
// ----------------------------------------------------------------------------
// imu_packet_to_hid_report_unit
// Turns decoded motion-sensor packets into one HID report per batch.
// ----------------------------------------------------------------------------
// a batch-closing beat passes the input register, then the report register
// throughput: one packet per cycle but for the stall below; the input register
//   feeds the state update and the report register in a single pass
// a stalled report holds back only a following batch-closing packet
// reset (aresetn low, synchronous) empties both registers and zeroes all
//   accel, gyro and mouse state
`default_nettype none

module imu_packet_to_hid_report_unit #(
    parameter int AVG_LOG2 = imuhid_pkg::AVG_LOG2_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input packets
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // quat_w_in, quat_x_in, quat_y_in, quat_z_in, accel_x, accel_y, accel_z,
    // gyro_x, gyro_y, gyro_z
    input  wire logic [imuhid_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                            s_tlast,   // last_in_batch
    // reports
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // mouse_dx, mouse_dy, joy_x, joy_y, joy_z, joy_rx, joy_ry, joy_rz,
    // quat_w_out, quat_x_out, quat_y_out, quat_z_out
    output logic [imuhid_pkg::M_DATA_W-1:0]      m_tdata
);

    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [imuhid_pkg::S_DATA_W-1:0] in_data_reg;
    logic                            in_last_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [imuhid_pkg::M_DATA_W-1:0] m_data_reg;
    logic [imuhid_pkg::M_DATA_W-1:0] m_data_next;
    logic                            load;
    logic                            advance;
    imuhid_pkg::ctl_t                ctl;

    imuhid_pkg::s32_t      q_in    [4];
    imuhid_pkg::s32_t      q_out   [4];
    imuhid_pkg::s16_t      accel   [imuhid_pkg::AXES];
    imuhid_pkg::s16_t      gyro    [imuhid_pkg::AXES];
    imuhid_pkg::s16_t      avg     [imuhid_pkg::AXES];
    imuhid_pkg::gyro_rpt_t gyro_rpt;

    // handshake: a held beat moves on unless it closes a batch and the
    // report register is still full
    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;
    assign ctl      = '{advance: advance, last: in_last_reg};

    // unpack the held beat
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q_in[i] = imuhid_pkg::s32_t'(in_data_reg[32*i +: 32]);
        end
        for (int j = 0; j < imuhid_pkg::AXES; j++) begin
            accel[j] = imuhid_pkg::s16_t'(in_data_reg[128 + 16*j +: 16]);
            gyro[j]  = imuhid_pkg::s16_t'(in_data_reg[176 + 16*j +: 16]);
        end
    end

    imuhid_accel #(
        .AVG_LOG2 (AVG_LOG2)
    ) u_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .accel   (accel),
        .avg     (avg)
    );

    imuhid_gyro u_gyro (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gyro    (gyro),
        .rpt     (gyro_rpt)
    );

    imuhid_quat u_quat (
        .q_in  (q_in),
        .q_out (q_out)
    );

    // pack the report, accel x and y swapped
    assign m_data_next = {q_out[3], q_out[2], q_out[1], q_out[0],
                          gyro_rpt.joy_rz, gyro_rpt.joy_ry, gyro_rpt.joy_rx,
                          avg[2], avg[0], avg[1],
                          gyro_rpt.mouse_dy, gyro_rpt.mouse_dx};

    // register valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a consumed batch-closing beat always yields a report
    a_report_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> m_tvalid)
        else $error("batch end consumed without a report");

    // a waiting report is never overwritten by the next batch end
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && in_valid_reg && in_last_reg |-> !advance)
        else $error("pending report overwritten");

    // input side stalls only while a beat is held
    a_stall_has_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // a non-closing beat never stalls
    a_plain_beat_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_last_reg |-> advance)
        else $error("plain packet held back");

endmodule

`default_nettype wire

@@ rtl/core/imuhid_accel.sv @@
// ----------------------------------------------------------------------------
// imuhid_accel
// Ring of recent accel samples with a moving sum per axis; gives the
// window average as it stands after the current beat.
// ----------------------------------------------------------------------------
`default_nettype none

module imuhid_accel #(
    parameter int AVG_LOG2 = imuhid_pkg::AVG_LOG2_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire imuhid_pkg::ctl_t  ctl,
    input  wire imuhid_pkg::s16_t  accel [imuhid_pkg::AXES],
    output imuhid_pkg::s16_t       avg   [imuhid_pkg::AXES]
);

    localparam int DEPTH = 1 << AVG_LOG2;
    localparam int POS_W = (AVG_LOG2 == 0) ? 1 : AVG_LOG2;
    localparam int SUM_W = 16 + AVG_LOG2;

    logic [15:0]      hist_reg [DEPTH][imuhid_pkg::AXES];
    logic [SUM_W-1:0] sum_reg  [imuhid_pkg::AXES];
    logic [SUM_W-1:0] sum_next [imuhid_pkg::AXES];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    // ring advances before the new sample lands
    assign pos_next = (AVG_LOG2 == 0) ? '0 : pos_reg + 1'b1;

    // drop the oldest sample, add the new one; average is the top 16 bits
    always_comb begin
        for (int j = 0; j < imuhid_pkg::AXES; j++) begin
            sum_next[j] = sum_reg[j]
                - {{AVG_LOG2{hist_reg[pos_next][j][15]}}, hist_reg[pos_next][j]}
                + {{AVG_LOG2{accel[j][15]}}, accel[j]};
            avg[j] = imuhid_pkg::s16_t'(sum_next[j][SUM_W-1 -: 16]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                for (int j = 0; j < imuhid_pkg::AXES; j++) begin
                    hist_reg[i][j] <= '0;
                end
            end
            for (int j = 0; j < imuhid_pkg::AXES; j++) begin
                sum_reg[j] <= '0;
            end
        end else if (ctl.advance) begin
            pos_reg <= pos_next;
            for (int j = 0; j < imuhid_pkg::AXES; j++) begin
                hist_reg[pos_next][j] <= accel[j];
                sum_reg[j]            <= sum_next[j];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/imuhid_gyro.sv @@
// ----------------------------------------------------------------------------
// imuhid_gyro
// Wrapping gyro totals, report snapshot and mouse reference; builds the
// saturated rate fields and the mouse deltas at a batch end.
// ----------------------------------------------------------------------------
`default_nettype none

module imuhid_gyro (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire imuhid_pkg::ctl_t      ctl,
    input  wire imuhid_pkg::s16_t      gyro [imuhid_pkg::AXES],
    output imuhid_pkg::gyro_rpt_t      rpt
);

    localparam logic [31:0] MOUSE_BIAS = 32'((1 << imuhid_pkg::MOUSE_SHIFT) - 1);
    localparam logic [15:0] SAT_MAX    = 16'h7fff;
    localparam logic [15:0] SAT_MIN    = 16'h8000;

    logic [31:0] tot_reg  [imuhid_pkg::AXES];
    logic [31:0] tot_next [imuhid_pkg::AXES];
    logic [31:0] rep_reg  [imuhid_pkg::AXES];
    logic [31:0] ref_reg  [imuhid_pkg::AXES];
    logic [31:0] ref_next [imuhid_pkg::AXES];
    logic [31:0] diff     [imuhid_pkg::AXES];
    logic [31:0] rem      [imuhid_pkg::AXES];
    logic [31:0] step     [imuhid_pkg::AXES];
    logic [15:0] sat      [imuhid_pkg::AXES];

    // clamp a 32-bit two's complement value to 16 bits
    function automatic logic [15:0] sat16(input logic [31:0] d);
        logic fits;
        fits = (d[31:15] == {17{1'b0}}) || (d[31:15] == {17{1'b1}});
        if (fits) begin
            return d[15:0];
        end
        return d[31] ? SAT_MIN : SAT_MAX;
    endfunction

    // totals, change since last report, mouse step truncated toward zero
    always_comb begin
        for (int j = 0; j < imuhid_pkg::AXES; j++) begin
            tot_next[j] = tot_reg[j] + {{16{gyro[j][15]}}, gyro[j]};
            diff[j]     = tot_next[j] - rep_reg[j];
            sat[j]      = sat16(diff[j]);
            rem[j]      = tot_next[j] - ref_reg[j];
            step[j]     = 32'($signed(rem[j] + (rem[j][31] ? MOUSE_BIAS : 32'd0))
                              >>> imuhid_pkg::MOUSE_SHIFT);
            ref_next[j] = ref_reg[j] + (step[j] << imuhid_pkg::MOUSE_SHIFT);
        end
    end

    // report fields with x and y rates swapped
    always_comb begin
        rpt.mouse_dx = imuhid_pkg::s8_t'(step[0][7:0]);
        rpt.mouse_dy = imuhid_pkg::s8_t'(8'd0 - step[1][7:0]);
        rpt.joy_rx   = imuhid_pkg::s16_t'(sat[1]);
        rpt.joy_ry   = imuhid_pkg::s16_t'(sat[0]);
        rpt.joy_rz   = imuhid_pkg::s16_t'(sat[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < imuhid_pkg::AXES; j++) begin
                tot_reg[j] <= '0;
                rep_reg[j] <= '0;
                ref_reg[j] <= '0;
            end
        end else if (ctl.advance) begin
            for (int j = 0; j < imuhid_pkg::AXES; j++) begin
                tot_reg[j] <= tot_next[j];
                if (ctl.last) begin
                    rep_reg[j] <= tot_next[j];
                    ref_reg[j] <= ref_next[j];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/imuhid_quat.sv @@
// ----------------------------------------------------------------------------
// imuhid_quat
// Halves a Q30 quaternion toward zero and rotates it 120 degrees about
// the (1,1,1) diagonal with wrapping sums.
// ----------------------------------------------------------------------------
`default_nettype none

module imuhid_quat (
    input  wire imuhid_pkg::s32_t  q_in  [4],
    output imuhid_pkg::s32_t       q_out [4]
);

    logic [31:0] h [4];

    // halve with truncation toward zero: add one to negatives, then floor
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            h[i] = 32'($signed(q_in[i] + {31'd0, q_in[i][31]}) >>> 1);
        end
    end

    // rotation sums
    always_comb begin
        q_out[0] = imuhid_pkg::s32_t'(h[0] - h[1] - h[2] - h[3]);
        q_out[1] = imuhid_pkg::s32_t'(h[0] + h[1] + h[2] - h[3]);
        q_out[2] = imuhid_pkg::s32_t'(h[0] - h[1] + h[2] + h[3]);
        q_out[3] = imuhid_pkg::s32_t'(h[0] + h[1] - h[2] + h[3]);
    end

endmodule

`default_nettype wire

@@ tb/imu_hid_report_checker.sv @@
// ----------------------------------------------------------------------------
// imu_hid_report_checker
// Watches the packet and report streams of the motion packet to HID report
// unit. Folds every accepted packet into its own copy of the accel window,
// gyro totals and mouse reference, queues the report that a batch-closing
// packet should produce, and compares each report beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_hid_report_checker #(
    parameter int AVG_LOG2 = imuhid_pkg::AVG_LOG2_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [imuhid_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [imuhid_pkg::M_DATA_W-1:0] m_tdata,
    output int                                   fail_count,
    output int                                   reports_owed
);

    // packet beat, last field in the top bits
    typedef struct packed {
        imuhid_pkg::s16_t gyro_z;
        imuhid_pkg::s16_t gyro_y;
        imuhid_pkg::s16_t gyro_x;
        imuhid_pkg::s16_t accel_z;
        imuhid_pkg::s16_t accel_y;
        imuhid_pkg::s16_t accel_x;
        imuhid_pkg::s32_t quat_z;
        imuhid_pkg::s32_t quat_y;
        imuhid_pkg::s32_t quat_x;
        imuhid_pkg::s32_t quat_w;
    } sensor_packet_t;

    // report beat, last field in the top bits
    typedef struct packed {
        imuhid_pkg::s32_t quat_z;
        imuhid_pkg::s32_t quat_y;
        imuhid_pkg::s32_t quat_x;
        imuhid_pkg::s32_t quat_w;
        imuhid_pkg::s16_t joy_rz;
        imuhid_pkg::s16_t joy_ry;
        imuhid_pkg::s16_t joy_rx;
        imuhid_pkg::s16_t joy_z;
        imuhid_pkg::s16_t joy_y;
        imuhid_pkg::s16_t joy_x;
        imuhid_pkg::s8_t  mouse_dy;
        imuhid_pkg::s8_t  mouse_dx;
    } hid_report_t;

    localparam int WINDOW     = 1 << AVG_LOG2;
    localparam int MOUSE_UNIT = 1 << imuhid_pkg::MOUSE_SHIFT;

    // shadow state of the unit
    imuhid_pkg::s16_t accel_ring [WINDOW][imuhid_pkg::AXES];
    imuhid_pkg::s32_t accel_sum [imuhid_pkg::AXES];
    int unsigned      ring_slot;
    imuhid_pkg::s32_t gyro_total [imuhid_pkg::AXES];
    imuhid_pkg::s32_t gyro_at_report [imuhid_pkg::AXES];
    imuhid_pkg::s32_t mouse_level [imuhid_pkg::AXES];

    hid_report_t reports_due [$];
    int          faults;
    int          report_no;

    // floor average of the window, low 16 bits
    function automatic imuhid_pkg::s16_t window_mean(input imuhid_pkg::s32_t sum);
        imuhid_pkg::s32_t m;
        m = sum >>> AVG_LOG2;
        return m[15:0];
    endfunction

    function automatic imuhid_pkg::s16_t clamp16(input imuhid_pkg::s32_t v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // advance the accel window and gyro totals, queue a report on batch end
    task automatic absorb_packet(input sensor_packet_t pkt, input logic closes_batch);
        imuhid_pkg::s16_t accel_in [imuhid_pkg::AXES];
        imuhid_pkg::s16_t gyro_in [imuhid_pkg::AXES];
        imuhid_pkg::s32_t half [4];
        imuhid_pkg::s32_t step [imuhid_pkg::AXES];
        imuhid_pkg::s16_t swing [imuhid_pkg::AXES];
        imuhid_pkg::s32_t lag;
        imuhid_pkg::s32_t dy_neg;
        hid_report_t      rpt;
        accel_in = '{pkt.accel_x, pkt.accel_y, pkt.accel_z};
        gyro_in  = '{pkt.gyro_x, pkt.gyro_y, pkt.gyro_z};
        ring_slot = (ring_slot + 1) % WINDOW;
        for (int a = 0; a < imuhid_pkg::AXES; a++) begin
            accel_sum[a] = accel_sum[a] - imuhid_pkg::s32_t'(accel_ring[ring_slot][a])
                           + imuhid_pkg::s32_t'(accel_in[a]);
            accel_ring[ring_slot][a] = accel_in[a];
            gyro_total[a] = gyro_total[a] + imuhid_pkg::s32_t'(gyro_in[a]);
        end
        if (!closes_batch)
            return;

        // gyro change since last report and mouse steps with carried remainder
        for (int a = 0; a < imuhid_pkg::AXES; a++) begin
            swing[a] = clamp16(gyro_total[a] - gyro_at_report[a]);
            gyro_at_report[a] = gyro_total[a];
            lag = gyro_total[a] - mouse_level[a];
            step[a] = lag / MOUSE_UNIT;
            mouse_level[a] = mouse_level[a] + step[a] * MOUSE_UNIT;
        end
        dy_neg = -step[1];

        // halve toward zero, then rotate about the diagonal
        half[0] = pkt.quat_w / 2;
        half[1] = pkt.quat_x / 2;
        half[2] = pkt.quat_y / 2;
        half[3] = pkt.quat_z / 2;

        rpt.mouse_dx = step[0][7:0];
        rpt.mouse_dy = dy_neg[7:0];
        rpt.joy_x    = window_mean(accel_sum[1]);
        rpt.joy_y    = window_mean(accel_sum[0]);
        rpt.joy_z    = window_mean(accel_sum[2]);
        rpt.joy_rx   = swing[1];
        rpt.joy_ry   = swing[0];
        rpt.joy_rz   = swing[2];
        rpt.quat_w   = half[0] - half[1] - half[2] - half[3];
        rpt.quat_x   = half[0] + half[1] + half[2] - half[3];
        rpt.quat_y   = half[0] - half[1] + half[2] + half[3];
        rpt.quat_z   = half[0] + half[1] - half[2] + half[3];
        reports_due.push_back(rpt);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: report %0d %s expected %0d got %0d",
                     $time, report_no, name, want, got);
            faults++;
        end
    endtask

    // compare report beats first, then fold in packet beats
    always @(posedge aclk) begin : watch
        hid_report_t want;
        hid_report_t got;
        if (!aresetn) begin
            for (int s = 0; s < WINDOW; s++)
                for (int a = 0; a < imuhid_pkg::AXES; a++)
                    accel_ring[s][a] = '0;
            for (int a = 0; a < imuhid_pkg::AXES; a++) begin
                accel_sum[a]      = '0;
                gyro_total[a]     = '0;
                gyro_at_report[a] = '0;
                mouse_level[a]    = '0;
            end
            ring_slot = 0;
            reports_due.delete();
            faults    = 0;
            report_no = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = hid_report_t'(m_tdata);
                if (reports_due.size() == 0) begin
                    $display("%0t: report beat expected none got %h",
                             $time, m_tdata);
                    faults++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("mouse_dx", int'(want.mouse_dx), int'(got.mouse_dx));
                    check_field("mouse_dy", int'(want.mouse_dy), int'(got.mouse_dy));
                    check_field("joy_x", int'(want.joy_x), int'(got.joy_x));
                    check_field("joy_y", int'(want.joy_y), int'(got.joy_y));
                    check_field("joy_z", int'(want.joy_z), int'(got.joy_z));
                    check_field("joy_rx", int'(want.joy_rx), int'(got.joy_rx));
                    check_field("joy_ry", int'(want.joy_ry), int'(got.joy_ry));
                    check_field("joy_rz", int'(want.joy_rz), int'(got.joy_rz));
                    check_field("quat_w_out", want.quat_w, got.quat_w);
                    check_field("quat_x_out", want.quat_x, got.quat_x);
                    check_field("quat_y_out", want.quat_y, got.quat_y);
                    check_field("quat_z_out", want.quat_z, got.quat_z);
                end
                report_no++;
            end
            if (s_tvalid && s_tready)
                absorb_packet(sensor_packet_t'(s_tdata), s_tlast);
        end
        fail_count   <= faults;
        reports_owed <= reports_due.size();
    end

endmodule

`default_nettype wire

@@ tb/imu_packet_to_hid_report_unit_tb.sv @@
// ----------------------------------------------------------------------------
// imu_packet_to_hid_report_unit_tb
// Drives sensor packets into the HID report unit: a directed set of extreme
// and corner packets, then random batches with random gaps on both streams
// and one long report stall that backs up the input. The checker beside the
// unit predicts and compares every report; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_packet_to_hid_report_unit_tb;

    // packet beat, last field in the top bits
    typedef struct packed {
        imuhid_pkg::s16_t gyro_z;
        imuhid_pkg::s16_t gyro_y;
        imuhid_pkg::s16_t gyro_x;
        imuhid_pkg::s16_t accel_z;
        imuhid_pkg::s16_t accel_y;
        imuhid_pkg::s16_t accel_x;
        imuhid_pkg::s32_t quat_z;
        imuhid_pkg::s32_t quat_y;
        imuhid_pkg::s32_t quat_x;
        imuhid_pkg::s32_t quat_w;
    } sensor_packet_t;

    localparam int PACKET_TARGET = 1300;
    localparam int CALM_FROM     = 1120;
    localparam int HOLD_OFF_AT   = 500;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_CYCLES  = 8;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // quat_w_in .. quat_z_in, accel_x .. z, gyro_x .. z
    logic [imuhid_pkg::S_DATA_W-1:0] s_tdata;
    logic                            s_tlast;   // last_in_batch
    logic                            m_tvalid;
    logic                            m_tready;
    // mouse_dx, mouse_dy, joy_x .. joy_rz, quat_w_out .. z
    logic [imuhid_pkg::M_DATA_W-1:0] m_tdata;
    int                              fail_count;
    int                              reports_owed;

    bit                              calm;
    bit                              gap_free;
    bit                              hold_off_req;
    bit                              hold_off_over;
    int                              packets_sent;

    // 10 unit clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    imu_packet_to_hid_report_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    imu_hid_report_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .reports_owed (reports_owed)
    );

    function automatic imuhid_pkg::s16_t pick16();
        unique case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return imuhid_pkg::s16_t'($urandom);
        endcase
    endfunction

    function automatic imuhid_pkg::s32_t pick32();
        unique case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return imuhid_pkg::s32_t'($urandom);
        endcase
    endfunction

    // gyro mostly small so the report deltas stay off the rails
    function automatic imuhid_pkg::s16_t pick_gyro();
        if ($urandom_range(0, 1) == 0)
            return imuhid_pkg::s16_t'(int'($urandom_range(0, 4000)) - 2000);
        return pick16();
    endfunction

    function automatic sensor_packet_t random_packet();
        sensor_packet_t p;
        p.quat_w  = pick32();
        p.quat_x  = pick32();
        p.quat_y  = pick32();
        p.quat_z  = pick32();
        p.accel_x = pick16();
        p.accel_y = pick16();
        p.accel_z = pick16();
        p.gyro_x  = pick_gyro();
        p.gyro_y  = pick_gyro();
        p.gyro_z  = pick_gyro();
        return p;
    endfunction

    function automatic sensor_packet_t uniform_packet(input imuhid_pkg::s32_t q,
                                                      input imuhid_pkg::s16_t a,
                                                      input imuhid_pkg::s16_t g);
        sensor_packet_t p;
        p.quat_w  = q;
        p.quat_x  = q;
        p.quat_y  = q;
        p.quat_z  = q;
        p.accel_x = a;
        p.accel_y = a;
        p.accel_z = a;
        p.gyro_x  = g;
        p.gyro_y  = g;
        p.gyro_z  = g;
        return p;
    endfunction

    // offer one beat, optionally after a gap, and wait for acceptance
    task automatic send_packet(input sensor_packet_t pkt, input logic last);
        if (!calm && !gap_free && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tdata  <= pkt;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        packets_sent++;
    endtask

    // report side: ready runs, stall bursts and one long hold-off
    initial begin : report_sink
        m_tready      = 1'b0;
        hold_off_over = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_off_req && !hold_off_over) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge aclk);
                hold_off_over = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat (150) @(negedge aclk);
                else
                    repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    // packet side and verdict
    initial begin : stimulus
        sensor_packet_t pkt;
        int             batch_len;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        calm          = 1'b0;
        gap_free      = 1'b0;
        hold_off_req  = 1'b0;
        packets_sent  = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // all zero, closes a batch
        send_packet(uniform_packet(32'sd0, 16'sd0, 16'sd0), 1'b1);
        // full positive window and gyro rail, only the fourth reports
        repeat (3) send_packet(uniform_packet(32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF), 1'b0);
        send_packet(uniform_packet(32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF), 1'b1);
        // full negative window, most negative quaternion, negative rail
        repeat (3) send_packet(uniform_packet(32'sh8000_0000, 16'sh8000, 16'sh8000), 1'b0);
        send_packet(uniform_packet(32'sh8000_0000, 16'sh8000, 16'sh8000), 1'b1);
        // small window values for the floor, odd quaternion halves
        send_packet(uniform_packet(-32'sd3, -16'sd1, 16'sd0), 1'b0);
        send_packet(uniform_packet(32'sd3, 16'sd1, 16'sd0), 1'b0);
        send_packet(uniform_packet(-32'sd1, 16'sd0, 16'sd0), 1'b0);
        send_packet(uniform_packet(32'sd1, -16'sd1, 16'sd0), 1'b1);
        // mouse steps truncate toward zero, remainder carried
        pkt = uniform_packet(32'sh4000_0000, 16'sd100, 16'sd0);
        pkt.gyro_x = -16'sd300;
        pkt.gyro_y = 16'sd300;
        pkt.gyro_z = -16'sd257;
        send_packet(pkt, 1'b1);
        pkt.gyro_x = -16'sd213;
        pkt.gyro_y = 16'sd213;
        pkt.gyro_z = 16'sd255;
        send_packet(pkt, 1'b1);
        pkt.gyro_x = 16'sd256;
        pkt.gyro_y = -16'sd256;
        pkt.gyro_z = 16'sd1;
        send_packet(pkt, 1'b1);
        // gyro change just inside and just past the 16-bit range
        send_packet(uniform_packet(32'sd0, 16'sd0, 16'sd32767), 1'b1);
        send_packet(uniform_packet(32'sd0, 16'sd0, 16'sd1), 1'b0);
        send_packet(uniform_packet(32'sd0, 16'sd0, 16'sd32767), 1'b1);
        send_packet(uniform_packet(32'sd0, 16'sd0, -16'sd32768), 1'b1);
        send_packet(uniform_packet(32'sd0, 16'sd0, -16'sd1), 1'b0);
        send_packet(uniform_packet(32'sd0, 16'sd0, -16'sd32768), 1'b1);

        // random batches
        while (packets_sent < PACKET_TARGET) begin
            if (packets_sent >= CALM_FROM)
                calm = 1'b1;
            if (!hold_off_req && packets_sent >= HOLD_OFF_AT) begin
                // back-to-back batch ends while reports are held off
                hold_off_req = 1'b1;
                while (!hold_off_over)
                    send_packet(random_packet(), 1'b1);
            end
            gap_free  = ($urandom_range(0, 3) == 0);
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6);
            for (int i = 1; i <= batch_len; i++)
                send_packet(random_packet(), i == batch_len);
        end
        s_tvalid <= 1'b0;

        while (reports_owed != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && reports_owed == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
